### rtl/tlbpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlbpt_pkg;

  localparam int ADDR_W      = 16;
  localparam int FRAME_OUT_W = 8;
  localparam int CNT_W       = 32;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [FRAME_OUT_W-1:0] frame_out_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

  // Saturating increment for the statistics counters.
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

endpackage

`default_nettype wire

### rtl/tlb_page_table_translator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  ---------------------------------------------
// in_       request    in_valid/in_stall   vaddr
// out_      result     out_valid/out_stall paddr, frame, tlb_hit, page_fault,
//                                          access_count, hit_count, fault_count
//
// One request per cycle sustained while out_stall is low; each request passes through the
// page table read register, then the result register.
// The page table read is registered; a same-page fill from the request just ahead is forwarded.
// After reset a clearing pass marks every one of the 2^(16-PAGE_BITS) page table entries
// (256 at the default) invalid, one entry per cycle, with in_stall held high throughout.
// out_stall holds the result register and raises in_stall once the lookup stage is full.

module tlb_page_table_translator
  import tlbpt_pkg::*;
#(
  parameter int PAGE_BITS   = 8,
  parameter int TLB_ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire addr_t            in_vaddr,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      addr_t            out_paddr,
  output      frame_out_t       out_frame,
  output      logic             out_tlb_hit,
  output      logic             out_page_fault,
  output      cnt_t             out_access_count,
  output      cnt_t             out_hit_count,
  output      cnt_t             out_fault_count
);

  localparam int VPN_W      = ADDR_W - PAGE_BITS;
  localparam int PAGE_COUNT = 1 << VPN_W;
  localparam int FP_W       = $clog2(TLB_ENTRIES);

  typedef logic [VPN_W-1:0] vpn_t;

  // ---------------------------------------------------------------------------
  // Page table memory: {valid, frame} per page
  // ---------------------------------------------------------------------------
  logic [VPN_W:0] pt_mem_r [PAGE_COUNT];
  logic [VPN_W:0] pt_rd_r;
  logic           pt_we;
  vpn_t           pt_waddr;
  logic [VPN_W:0] pt_wdata;

  // Clearing pass after reset
  logic clr_busy_r, clr_busy_nxt;
  vpn_t clr_idx_r, clr_idx_nxt;

  // Lookup stage
  logic  s1_valid_r, s1_valid_nxt;
  addr_t s1_addr_r;
  logic  byp_r;
  vpn_t  byp_frame_r;

  // TLB
  vpn_t            tlb_tag_r [TLB_ENTRIES];
  vpn_t            tlb_frm_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_vld_r;
  logic [FP_W-1:0] fill_ptr_r, fill_ptr_nxt;

  // Allocator and statistics
  vpn_t alloc_frame_r;
  cnt_t acc_cnt_r, hit_cnt_r, flt_cnt_r;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  addr_t      out_pa_r;
  frame_out_t out_frame_r;
  logic       out_hit_r;
  logic       out_fault_r;

  // Datapath signals
  logic  in_acc;
  logic  s1_adv;
  logic  commit;
  vpn_t  in_page;
  vpn_t  s1_page;
  logic  tlb_hit;
  vpn_t  tlb_frame;
  logic  pt_valid;
  vpn_t  pt_frame;
  logic  fault;
  vpn_t  frame;
  logic  pt_commit_wr;
  logic [ADDR_W-1:0] frame_ext;

  // ---------------------------------------------------------------------------
  // Handshake: advance the lookup stage when the result register is free or drains
  // ---------------------------------------------------------------------------
  assign s1_adv   = ~out_valid_r | ~out_stall;
  assign commit   = s1_valid_r & s1_adv;
  assign in_stall = clr_busy_r | (s1_valid_r & ~s1_adv);
  assign in_acc   = in_valid & ~in_stall;

  assign in_page = in_vaddr[ADDR_W-1 -: VPN_W];
  assign s1_page = s1_addr_r[ADDR_W-1 -: VPN_W];

  // ---------------------------------------------------------------------------
  // TLB lookup: compare all entries in parallel, lowest matching entry wins
  // ---------------------------------------------------------------------------
  always_comb begin
    tlb_hit   = 1'b0;
    tlb_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_vld_r[i] && (tlb_tag_r[i] == s1_page)) begin
        tlb_hit   = 1'b1;
        tlb_frame = tlb_frm_r[i];
      end
    end
  end

  // Page table entry, with the fill from the request just ahead forwarded
  assign pt_valid = byp_r | pt_rd_r[VPN_W];
  assign pt_frame = byp_r ? byp_frame_r : pt_rd_r[VPN_W-1:0];

  assign fault        = ~tlb_hit & ~pt_valid;
  assign frame        = tlb_hit ? tlb_frame : (pt_valid ? pt_frame : alloc_frame_r);
  assign pt_commit_wr = commit & fault;
  assign frame_ext    = ADDR_W'(frame);

  // ---------------------------------------------------------------------------
  // Memory write port: clearing pass or fault fill
  // ---------------------------------------------------------------------------
  always_comb begin
    pt_we    = clr_busy_r | pt_commit_wr;
    pt_waddr = clr_busy_r ? clr_idx_r : s1_page;
    pt_wdata = clr_busy_r ? '0 : {1'b1, alloc_frame_r};
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem_r[pt_waddr] <= pt_wdata;
    end
    if (in_acc) begin
      pt_rd_r <= pt_mem_r[in_page];
    end
  end

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    clr_idx_nxt  = clr_idx_r + vpn_t'(1);
    clr_busy_nxt = clr_busy_r & (clr_idx_r != {VPN_W{1'b1}});
    s1_valid_nxt = in_acc | (s1_valid_r & ~s1_adv);
    out_valid_nxt = commit | (out_valid_r & out_stall);
    fill_ptr_nxt = (fill_ptr_r == FP_W'(TLB_ENTRIES - 1)) ? '0 : fill_ptr_r + FP_W'(1);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r    <= 1'b1;
      clr_idx_r     <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      byp_r         <= 1'b0;
      tlb_vld_r     <= '0;
      fill_ptr_r    <= '0;
      alloc_frame_r <= '0;
      acc_cnt_r     <= '0;
      hit_cnt_r     <= '0;
      flt_cnt_r     <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_busy_r <= clr_busy_nxt;
        clr_idx_r  <= clr_idx_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // Forward only when the fill lands on the same edge this request reads
      if (in_acc) begin
        byp_r <= pt_commit_wr & (in_page == s1_page);
      end
      if (commit) begin
        acc_cnt_r <= sat_inc(acc_cnt_r);
        if (tlb_hit) begin
          hit_cnt_r <= sat_inc(hit_cnt_r);
        end else begin
          tlb_vld_r[fill_ptr_r] <= 1'b1;
          fill_ptr_r            <= fill_ptr_nxt;
        end
        if (fault) begin
          flt_cnt_r     <= sat_inc(flt_cnt_r);
          alloc_frame_r <= alloc_frame_r + vpn_t'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r   <= in_vaddr;
      byp_frame_r <= alloc_frame_r;
    end
    if (commit) begin
      if (!tlb_hit) begin
        tlb_tag_r[fill_ptr_r] <= s1_page;
        tlb_frm_r[fill_ptr_r] <= frame;
      end
      out_pa_r    <= {frame, s1_addr_r[PAGE_BITS-1:0]};
      out_frame_r <= frame_ext[FRAME_OUT_W-1:0];
      out_hit_r   <= tlb_hit;
      out_fault_r <= fault;
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs: the counters change only with a new result, so drive them directly
  // ---------------------------------------------------------------------------
  assign out_valid        = out_valid_r;
  assign out_paddr        = out_pa_r;
  assign out_frame        = out_frame_r;
  assign out_tlb_hit      = out_hit_r;
  assign out_page_fault   = out_fault_r;
  assign out_access_count = acc_cnt_r;
  assign out_hit_count    = hit_cnt_r;
  assign out_fault_count  = flt_cnt_r;

endmodule

`default_nettype wire

### rtl/tlbpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_checker
  import tlbpt_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire addr_t      out_paddr,
  input wire frame_out_t out_frame,
  input wire logic       out_tlb_hit,
  input wire logic       out_page_fault,
  input wire cnt_t       out_access_count,
  input wire cnt_t       out_hit_count,
  input wire cnt_t       out_fault_count
);

  logic out_acc;
  logic seen_r;
  cnt_t prev_acc_r, prev_hit_r, prev_flt_r;

  assign out_acc = out_valid & ~out_stall;

  // Track the counters of the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_acc) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_acc_r <= out_access_count;
      prev_hit_r <= out_hit_count;
      prev_flt_r <= out_fault_count;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_paddr)
      && $stable(out_frame) && $stable(out_tlb_hit) && $stable(out_page_fault))
    else $error("stalled result changed");

  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> !(out_tlb_hit && out_page_fault) && (out_access_count >= out_hit_count))
    else $error("hit and fault flags or counters inconsistent");

  a_acc_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r && (prev_acc_r != CNT_MAX) |-> out_access_count == prev_acc_r + cnt_t'(1))
    else $error("access count did not advance by one");

  a_hit_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r && (prev_hit_r != CNT_MAX)
      |-> out_hit_count == prev_hit_r + cnt_t'(out_tlb_hit))
    else $error("hit count does not follow hit flag");

  a_flt_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r && (prev_flt_r != CNT_MAX)
      |-> out_fault_count == prev_flt_r + cnt_t'(out_page_fault))
    else $error("fault count does not follow fault flag");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

`default_nettype wire

### tb/tlbpt_checker.sv
`timescale 1ns / 1ps

module tlbpt_scoreboard
  import tlbpt_pkg::*;
#(
  parameter int PAGE_BITS   = 8,
  parameter int TLB_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  addr_t       in_vaddr,
  input  logic        out_valid,
  input  logic        out_stall,
  input  addr_t       out_paddr,
  input  frame_out_t  out_frame,
  input  logic        out_tlb_hit,
  input  logic        out_page_fault,
  input  cnt_t        out_access_count,
  input  cnt_t        out_hit_count,
  input  cnt_t        out_fault_count,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int PAGE_W       = ADDR_W - PAGE_BITS;
  localparam int PAGE_COUNT   = 1 << PAGE_W;
  localparam int REPORT_LIMIT = 10;

  typedef logic [PAGE_W-1:0] page_t;

  typedef struct packed {
    addr_t      phys;
    frame_out_t frame;
    logic       hit;
    logic       fault;
    cnt_t       accesses;
    cnt_t       hits;
    cnt_t       faults;
  } xlat_t;

  page_t       tlb_tag   [TLB_ENTRIES];
  page_t       tlb_frame [TLB_ENTRIES];
  bit          tlb_live  [TLB_ENTRIES];
  int unsigned fill_slot;
  page_t       pt_frame  [PAGE_COUNT];
  bit          pt_live   [PAGE_COUNT];
  page_t       alloc_frame;
  cnt_t        accesses;
  cnt_t        hits;
  cnt_t        faults;

  xlat_t       translations_due[$];
  xlat_t       head;
  int unsigned errors = 0;

  task automatic clear_model();
    for (int i = 0; i < TLB_ENTRIES; i++) tlb_live[i] = 1'b0;
    for (int i = 0; i < PAGE_COUNT; i++) pt_live[i] = 1'b0;
    fill_slot   = 0;
    alloc_frame = '0;
    accesses    = '0;
    hits        = '0;
    faults      = '0;
  endtask

  // Translate one address and advance the TLB, page table and counters.
  function automatic xlat_t translate(input addr_t la);
    page_t pg;
    page_t frm;
    logic  hit;
    logic  flt;
    xlat_t r;
    pg  = la[ADDR_W-1:PAGE_BITS];
    frm = '0;
    hit = 1'b0;
    flt = 1'b0;
    if (accesses != CNT_MAX) accesses++;
    // lowest matching live slot wins
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!hit && tlb_live[i] && tlb_tag[i] == pg) begin
        frm = tlb_frame[i];
        hit = 1'b1;
      end
    end
    if (hit) begin
      if (hits != CNT_MAX) hits++;
    end else begin
      if (!pt_live[pg]) begin
        pt_frame[pg] = alloc_frame;
        pt_live[pg]  = 1'b1;
        alloc_frame++;
        flt = 1'b1;
        if (faults != CNT_MAX) faults++;
      end
      frm                  = pt_frame[pg];
      tlb_tag[fill_slot]   = pg;
      tlb_frame[fill_slot] = frm;
      tlb_live[fill_slot]  = 1'b1;
      fill_slot            = (fill_slot + 1) % TLB_ENTRIES;
    end
    r.phys     = {frm, la[PAGE_BITS-1:0]};
    r.frame    = frame_out_t'(frm);
    r.hit      = hit;
    r.fault    = flt;
    r.accesses = accesses;
    r.hits     = hits;
    r.faults   = faults;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("checker: %s mismatch at %0t ns: expected %h, got %h",
                 name, $time, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      translations_due.delete();
    end else begin
      // retire before accepting, so a result never pairs with a same-edge request
      if (out_valid && !out_stall) begin
        if (translations_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("checker: unexpected result at %0t ns: physical %h",
                     $time, out_paddr);
        end else begin
          head = translations_due.pop_front();
          check_field("paddr", CNT_W'(head.phys), CNT_W'(out_paddr));
          check_field("frame", CNT_W'(head.frame), CNT_W'(out_frame));
          check_field("tlb_hit", CNT_W'(head.hit), CNT_W'(out_tlb_hit));
          check_field("page_fault", CNT_W'(head.fault), CNT_W'(out_page_fault));
          check_field("access_count", head.accesses, out_access_count);
          check_field("hit_count", head.hits, out_hit_count);
          check_field("fault_count", head.faults, out_fault_count);
        end
      end
      if (in_valid && !in_stall)
        translations_due.push_back(translate(in_vaddr));
    end
    mismatches  <= errors;
    outstanding <= translations_due.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tlbpt_pkg::*;

  localparam int PAGE_BITS      = 8;
  localparam int TLB_ENTRIES    = 16;
  localparam int PAGE_W         = ADDR_W - PAGE_BITS;
  localparam int PAGE_COUNT     = 1 << PAGE_W;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int IDLE_PCT       = 17;
  localparam int HOLD_CYCLES    = 60;   // receiver hold-off, long enough to back up the pipe
  localparam int BURST_ITEMS    = 24;   // requests offered during a hold-off
  localparam int RANDOM_ITEMS   = 1350;
  localparam int SET_REFRESH    = 200;  // requests between working-set changes
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 4000; // covers the page-table clearing pass after reset

  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [PAGE_BITS-1:0] offset_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  addr_t       in_vaddr         = '0;
  logic        out_stall        = 1'b0;
  logic        in_stall;
  logic        out_valid;
  addr_t       out_paddr;
  frame_out_t  out_frame;
  logic        out_tlb_hit;
  logic        out_page_fault;
  cnt_t        out_access_count;
  cnt_t        out_hit_count;
  cnt_t        out_fault_count;
  int unsigned mismatches;
  int unsigned outstanding;

  // Idle percentages of both sides, changed by the stimulus phases.
  int unsigned gap_pct   = IDLE_PCT;
  int unsigned stall_pct = IDLE_PCT;
  // Raised by the sender to ask the receiver for one long hold-off.
  bit          sink_hold_req = 1'b0;
  int unsigned quiet_cycles  = 0;

  always #(HALF_PERIOD) clk = ~clk;

  tlb_page_table_translator #(
    .PAGE_BITS   (PAGE_BITS),
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_vaddr         (in_vaddr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_paddr        (out_paddr),
    .out_frame        (out_frame),
    .out_tlb_hit      (out_tlb_hit),
    .out_page_fault   (out_page_fault),
    .out_access_count (out_access_count),
    .out_hit_count    (out_hit_count),
    .out_fault_count  (out_fault_count)
  );

  tlbpt_scoreboard #(
    .PAGE_BITS   (PAGE_BITS),
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_vaddr         (in_vaddr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_paddr        (out_paddr),
    .out_frame        (out_frame),
    .out_tlb_hit      (out_tlb_hit),
    .out_page_fault   (out_page_fault),
    .out_access_count (out_access_count),
    .out_hit_count    (out_hit_count),
    .out_fault_count  (out_fault_count),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Build an address from a page number and an offset.
  function automatic addr_t join_addr(input page_t pg, input int unsigned off);
    return {pg, offset_t'(off)};
  endfunction

  // Offer one request: idle at random first, then hold valid and the address
  // until the block takes the request. Returns on the accepting edge.
  task automatic send_request(input addr_t la);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vaddr <= la;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Drop valid and wait until every predicted translation has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Ask the receiver for a long hold-off and keep offering requests without
  // gaps, so the pipe fills and in_stall rises.
  task automatic stall_burst();
    int unsigned saved_gap;
    saved_gap     = gap_pct;
    gap_pct       = 0;
    sink_hold_req = 1'b1;
    repeat (BURST_ITEMS) send_request(addr_t'($urandom()));
    gap_pct = saved_gap;
  endtask

  // Receiver: random stalls, and one long hold-off whenever the sender asks,
  // counted here in cycles.
  initial begin : result_sink
    int unsigned held;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    page_t hot_pages  [TLB_ENTRIES-4];
    page_t wide_pages [TLB_ENTRIES+8];
    page_t sweep_order[PAGE_COUNT];
    page_t swap_page;
    int    i;
    int    j;
    int    n;
    int    pick;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Cold faults at both ends of the address space, then hits
    // on the same pages with the other offset extreme.
    send_request(16'h0000);
    send_request(16'h00FF);
    send_request(16'hFFFF);
    send_request(16'hFF00);
    // Fault in one page per TLB slot: the FIFO wraps and evicts pages 0 and FF.
    for (i = 1; i <= TLB_ENTRIES; i++)
      send_request(join_addr(page_t'(i), i * 37));
    // Evicted pages now miss the TLB but hit the page table (no fault).
    send_request(16'h0040);
    send_request(16'hFF80);
    // Checkerboard patterns: fresh faults with alternating bits.
    send_request(16'hA55A);
    send_request(16'h5AA5);
    drain_results();

    // Back-pressure: long receiver hold-off while the sender keeps offering.
    stall_burst();
    drain_results();

    // Touch every page once, in random order, so every page is faulted in and the frame allocator wraps.
    for (i = 0; i < PAGE_COUNT; i++) sweep_order[i] = page_t'(i);
    for (i = PAGE_COUNT - 1; i > 0; i--) begin
      j              = $urandom_range(i);
      swap_page      = sweep_order[i];
      sweep_order[i] = sweep_order[j];
      sweep_order[j] = swap_page;
    end
    for (i = 0; i < PAGE_COUNT; i++)
      send_request(join_addr(sweep_order[i], $urandom()));

    // Random part. Half from a hot set smaller than the TLB (hits), a quarter from a
    // wider set that thrashes the TLB (page-table hits), the rest uniform.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SET_REFRESH == 0) begin
        foreach (hot_pages[k]) hot_pages[k] = page_t'($urandom());
        foreach (wide_pages[k]) wide_pages[k] = page_t'($urandom());
      end
      // hold a stretch with no idling on either side
      if (n >= 500 && n < 800) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = IDLE_PCT;
        stall_pct = IDLE_PCT;
      end
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
        stall_burst();
      end
      pick = $urandom_range(99);
      if (pick < 50)
        send_request(join_addr(hot_pages[$urandom_range(TLB_ENTRIES-5)], $urandom()));
      else if (pick < 75)
        send_request(join_addr(wide_pages[$urandom_range(TLB_ENTRIES+7)], $urandom()));
      else
        send_request(addr_t'($urandom()));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tlbpt_pkg.sv
rtl/tlb_page_table_translator.sv
rtl/tlbpt_checker.sv
tb/tlbpt_checker.sv
tb/tb.sv
